/* sv/pc_pkg.sv */
`timescale 1ns / 1ps
// Package for the correlation block: widths, payload types and engine interface types.
package pc_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int PAIR_LIMIT   = 4096;

   localparam int COUNT_W = $clog2(PAIR_LIMIT + 1);
   localparam int PROD_W  = 2 * SAMPLE_WIDTH;
   localparam int SUM_W   = SAMPLE_WIDTH + COUNT_W - 1;
   localparam int PSUM_W  = PROD_W + COUNT_W - 1;
   localparam int SQSUM_W = PROD_W + COUNT_W - 2;

   localparam int COEF_W = 16;
   localparam int FRAC_W = COEF_W - 1;
   localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] x_sample;
      logic signed [SAMPLE_WIDTH-1:0] y_sample;
      logic                           last_pair;
   } pc_req_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] coefficient;
      logic                     zero_spread;
      logic                     count_overflow;
   } pc_rsp_type;

   typedef struct packed {
      logic        [COUNT_W-1:0] pair_count;
      logic signed [SUM_W-1:0]   sum_of_x;
      logic signed [SUM_W-1:0]   sum_of_y;
      logic signed [PSUM_W-1:0]  sum_of_products;
      logic        [SQSUM_W-1:0] sum_of_x_squares;
      logic        [SQSUM_W-1:0] sum_of_y_squares;
   } pc_sums_type;

   typedef struct packed {
      logic start;
      logic ack;
   } pc_fin_ctl_type;

   typedef struct packed {
      logic       done;
      pc_rsp_type result;
   } pc_fin_sts_type;

endpackage

/* sv/pearson_correlation.sv */
`timescale 1ns / 1ps
// Top level of the streaming Pearson correlation block.
//
//   channel   dir   handshake              payload
//   req_      in    req_valid / req_ready  pc_req_type (x_sample, y_sample, last_pair)
//   rsp_      out   rsp_valid / rsp_ready  pc_rsp_type (coefficient, zero_spread,
//                                                       count_overflow)
//
// Each pair is accepted in S_IDLE and then takes three passes through the single
//   16x16 multiplier for x*y, x*x and y*y; the next pair is taken back in S_IDLE.
// The last pair then goes through S_TAIL, where its y*y is summed, and pc_finish: the
//   shared 112-bit adder does the seven shift-add products, the 56-step square root,
//   one abs step and, unless the root is zero, the 16-step divide. An overflowed set
//   skips that pass; S_TAIL sets its flag once the output register is free.
// Reset clears the running sums, the pair count, both state machines and the pend, overflow and valid flags.
// A result waits in the output register; the next set's pairs keep flowing in, and
//   only the next result transfer stalls until the held one is taken.
module pearson_correlation (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  pc_pkg::pc_req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output pc_pkg::pc_rsp_type rsp_payload
);
   import pc_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_XY, S_XX, S_YY, S_TAIL, S_FIN} state_type;

   state_type state_ff, state_in;

   // sample holding registers
   logic signed [SAMPLE_WIDTH-1:0] x_ff, x_in;
   logic signed [SAMPLE_WIDTH-1:0] y_ff, y_in;
   logic                           last_ff, last_in;
   logic                           acc_en_ff, acc_en_in;   // pair fits under PAIR_LIMIT

   // shared multiplier and its registered product
   logic signed [SAMPLE_WIDTH-1:0] mul_a, mul_b;
   logic signed [PROD_W-1:0]       mul_p;
   logic signed [PROD_W-1:0]       prod_ff, prod_in;
   logic                           pend_ff, pend_in;       // y*y still to be summed

   // running sums
   logic        [COUNT_W-1:0] count_ff, count_in;
   logic signed [SUM_W-1:0]   sx_ff, sx_in;
   logic signed [SUM_W-1:0]   sy_ff, sy_in;
   logic signed [PSUM_W-1:0]  sxy_ff, sxy_in;
   logic        [SQSUM_W-1:0] sxx_ff, sxx_in;
   logic        [SQSUM_W-1:0] syy_ff, syy_in;
   logic                      ovf_ff, ovf_in;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   pc_rsp_type rsp_ff, rsp_in;

   pc_sums_type    sums;
   pc_fin_ctl_type fin_ctl;
   pc_fin_sts_type fin_sts;

   logic req_xfer;
   logic slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign mul_p = mul_a * mul_b;

   assign sums.pair_count       = count_ff;
   assign sums.sum_of_x         = sx_ff;
   assign sums.sum_of_y         = sy_ff;
   assign sums.sum_of_products  = sxy_ff;
   assign sums.sum_of_x_squares = sxx_ff;
   assign sums.sum_of_y_squares = syy_ff;

   // the sums stay put while the engine runs, so it reads them live
   assign fin_ctl.start = (state_ff == S_TAIL) && !pend_ff && !ovf_ff;
   assign fin_ctl.ack   = (state_ff == S_FIN) && fin_sts.done && slot_free;

   pc_finish u_finish (
      .clock (clock),
      .reset (reset),
      .sums  (sums),
      .ctl   (fin_ctl),
      .sts   (fin_sts)
   );

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      last_in      = last_ff;
      acc_en_in    = acc_en_ff;
      prod_in      = prod_ff;
      pend_in      = pend_ff;
      count_in     = count_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      sxy_in       = sxy_ff;
      sxx_in       = sxx_ff;
      syy_in       = syy_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      mul_a        = x_ff;
      mul_b        = y_ff;

      // fold in the previous pair's y*y while idle or in the tail
      if (pend_ff && (state_ff == S_IDLE || state_ff == S_TAIL)) begin
         if (acc_en_ff) begin
            syy_in = syy_ff + SQSUM_W'($unsigned(prod_ff));
         end
         pend_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               x_in      = req_payload.x_sample;
               y_in      = req_payload.y_sample;
               last_in   = req_payload.last_pair;
               acc_en_in = (count_ff != COUNT_W'(PAIR_LIMIT));
               state_in  = S_XY;
            end
         end

         S_XY: begin
            prod_in = mul_p;
            if (acc_en_ff) begin
               count_in = count_ff + COUNT_W'(1);
               sx_in    = sx_ff + SUM_W'(x_ff);
               sy_in    = sy_ff + SUM_W'(y_ff);
            end else begin
               ovf_in = 1'b1;
            end
            state_in = S_XX;
         end

         S_XX: begin
            mul_b   = x_ff;
            prod_in = mul_p;
            if (acc_en_ff) begin
               sxy_in = sxy_ff + PSUM_W'(prod_ff);
            end
            state_in = S_YY;
         end

         S_YY: begin
            mul_a   = y_ff;
            prod_in = mul_p;
            pend_in = 1'b1;
            if (acc_en_ff) begin
               sxx_in = sxx_ff + SQSUM_W'($unsigned(prod_ff));
            end
            state_in = last_ff ? S_TAIL : S_IDLE;
         end

         S_TAIL: begin
            if (!pend_ff) begin
               if (!ovf_ff) begin
                  state_in = S_FIN;
               end else if (slot_free) begin
                  // too many pairs: flag only, no arithmetic
                  rsp_in.coefficient    = '0;
                  rsp_in.zero_spread    = 1'b0;
                  rsp_in.count_overflow = 1'b1;
                  rsp_valid_in          = 1'b1;
                  count_in              = '0;
                  sx_in                 = '0;
                  sy_in                 = '0;
                  sxy_in                = '0;
                  sxx_in                = '0;
                  syy_in                = '0;
                  ovf_in                = 1'b0;
                  state_in              = S_IDLE;
               end
            end
         end

         S_FIN: begin
            if (fin_ctl.ack) begin
               rsp_in       = fin_sts.result;
               rsp_valid_in = 1'b1;
               count_in     = '0;
               sx_in        = '0;
               sy_in        = '0;
               sxy_in       = '0;
               sxx_in       = '0;
               syy_in       = '0;
               ovf_in       = 1'b0;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         sx_ff        <= '0;
         sy_ff        <= '0;
         sxy_ff       <= '0;
         sxx_ff       <= '0;
         syy_ff       <= '0;
         ovf_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         sx_ff        <= sx_in;
         sy_ff        <= sy_in;
         sxy_ff       <= sxy_in;
         sxx_ff       <= sxx_in;
         syy_ff       <= syy_in;
         ovf_ff       <= ovf_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      y_ff      <= y_in;
      last_ff   <= last_in;
      acc_en_ff <= acc_en_in;
      prod_ff   <= prod_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* sv/pc_finish.sv */
`timescale 1ns / 1ps
// End-of-set engine: variances, covariance, square root and divide on one shared adder.
module pc_finish (
   input  logic                   clock,
   input  logic                   reset,
   input  pc_pkg::pc_sums_type    sums,
   input  pc_pkg::pc_fin_ctl_type ctl,
   output pc_pkg::pc_fin_sts_type sts
);
   import pc_pkg::*;

   localparam int NUM_W  = COUNT_W + PSUM_W;
   localparam int VAR_W  = COUNT_W + SQSUM_W - 1;
   localparam int ROOT_W = VAR_W + 1;
   localparam int AW     = 2 * ROOT_W;
   localparam int CNT_W  = $clog2(ROOT_W);

   typedef enum logic [2:0] {F_IDLE, F_MUL, F_SQRT, F_ABS, F_DIV, F_DONE} fstate_type;
   typedef enum logic [2:0] {
      M_NSXY, M_SXSY, M_NSXX, M_SXSX, M_NSYY, M_SYSY, M_VXVY
   } mop_type;

   fstate_type state_ff, state_in;
   mop_type    mop_ff, mop_in, ld_op;

   logic [AW-1:0]           acc_ff, acc_in;
   logic [AW-1:0]           mcand_ff, mcand_in;
   logic [VAR_W-1:0]        mplier_ff, mplier_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    msub_ff, msub_in;
   logic                    msgn_ff, msgn_in;
   logic signed [NUM_W-1:0] num_ff, num_in;
   logic [VAR_W-1:0]        vx_ff, vx_in;
   logic [AW-1:0]           p_ff, p_in;
   logic [ROOT_W-1:0]       root_ff, root_in;
   logic                    neg_ff, neg_in;
   logic [COEF_W-1:0]       q_ff, q_in;
   pc_rsp_type              res_ff, res_in;

   // shared adder / subtractor, carry out is the unsigned a >= b flag on subtract
   logic [AW-1:0] alu_a, alu_b;
   logic          alu_sub;
   logic [AW:0]   alu_res;
   logic          alu_carry;

   assign alu_res   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                      + {{AW{1'b0}}, alu_sub};
   assign alu_carry = alu_res[AW];

   logic [AW-1:0]     acc_step;
   logic [AW-1:0]     rem_sh;
   logic              last_step;
   logic [COEF_W-1:0] q_fin;

   logic [AW-1:0]    ld_mcand;
   logic [VAR_W-1:0] ld_mplier;
   logic [CNT_W-1:0] ld_cnt;
   logic             ld_sub;
   logic             ld_sgn;

   assign last_step = (cnt_ff == '0);
   assign rem_sh    = {acc_ff[AW-3:0], p_ff[AW-1:AW-2]};
   assign acc_step  = mplier_ff[0] ? alu_res[AW-1:0] : acc_ff;
   assign q_fin     = {q_ff[COEF_W-2:0], alu_carry};

   // operand selection for the next multiply op
   always_comb begin
      ld_op = M_NSXY;
      if (state_ff == F_MUL) begin
         case (mop_ff)
            M_NSXY:  ld_op = M_SXSY;
            M_SXSY:  ld_op = M_NSXX;
            M_NSXX:  ld_op = M_SXSX;
            M_SXSX:  ld_op = M_NSYY;
            M_NSYY:  ld_op = M_SYSY;
            M_SYSY:  ld_op = M_VXVY;
            default: ld_op = M_NSXY;
         endcase
      end
      ld_mcand  = '0;
      ld_mplier = '0;
      ld_cnt    = '0;
      ld_sub    = 1'b0;
      ld_sgn    = 1'b0;
      case (ld_op)
         M_NSXY: begin
            ld_mcand  = AW'(sums.sum_of_products);
            ld_mplier = VAR_W'(sums.pair_count);
            ld_cnt    = CNT_W'(COUNT_W - 1);
         end
         M_SXSY: begin
            ld_mcand  = AW'(sums.sum_of_x);
            ld_mplier = VAR_W'(sums.sum_of_y);
            ld_cnt    = CNT_W'(SUM_W - 1);
            ld_sub    = 1'b1;
            ld_sgn    = 1'b1;
         end
         M_NSXX: begin
            ld_mcand  = AW'(sums.sum_of_x_squares);
            ld_mplier = VAR_W'(sums.pair_count);
            ld_cnt    = CNT_W'(COUNT_W - 1);
         end
         M_SXSX: begin
            ld_mcand  = AW'(sums.sum_of_x);
            ld_mplier = VAR_W'(sums.sum_of_x);
            ld_cnt    = CNT_W'(SUM_W - 1);
            ld_sub    = 1'b1;
            ld_sgn    = 1'b1;
         end
         M_NSYY: begin
            ld_mcand  = AW'(sums.sum_of_y_squares);
            ld_mplier = VAR_W'(sums.pair_count);
            ld_cnt    = CNT_W'(COUNT_W - 1);
         end
         M_SYSY: begin
            ld_mcand  = AW'(sums.sum_of_y);
            ld_mplier = VAR_W'(sums.sum_of_y);
            ld_cnt    = CNT_W'(SUM_W - 1);
            ld_sub    = 1'b1;
            ld_sgn    = 1'b1;
         end
         M_VXVY: begin
            // Vy comes straight out of the accumulator
            ld_mcand  = AW'(acc_step[VAR_W-1:0]);
            ld_mplier = vx_ff;
            ld_cnt    = CNT_W'(VAR_W - 1);
         end
         default: begin
            ld_mcand = '0;
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      mop_in    = mop_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      msub_in   = msub_ff;
      msgn_in   = msgn_ff;
      num_in    = num_ff;
      vx_in     = vx_ff;
      p_in      = p_ff;
      root_in   = root_ff;
      neg_in    = neg_ff;
      q_in      = q_ff;
      res_in    = res_ff;
      alu_a     = '0;
      alu_b     = '0;
      alu_sub   = 1'b0;

      case (state_ff)
         F_IDLE: begin
            if (ctl.start) begin
               mop_in    = M_NSXY;
               acc_in    = '0;
               mcand_in  = ld_mcand;
               mplier_in = ld_mplier;
               cnt_in    = ld_cnt;
               msub_in   = ld_sub;
               msgn_in   = ld_sgn;
               state_in  = F_MUL;
            end
         end

         F_MUL: begin
            // shift-add; a signed multiplier's top bit weighs negative
            alu_a     = acc_ff;
            alu_b     = mcand_ff;
            alu_sub   = msub_ff ^ (last_step & msgn_ff);
            acc_in    = acc_step;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff - CNT_W'(1);
            if (last_step) begin
               mop_in    = ld_op;
               mcand_in  = ld_mcand;
               mplier_in = ld_mplier;
               cnt_in    = ld_cnt;
               msub_in   = ld_sub;
               msgn_in   = ld_sgn;
               case (mop_ff)
                  M_SXSY: begin
                     num_in = acc_step[NUM_W-1:0];
                     acc_in = '0;
                  end
                  M_SXSX: begin
                     vx_in  = acc_step[VAR_W-1:0];
                     acc_in = '0;
                  end
                  M_SYSY: begin
                     acc_in = '0;
                  end
                  M_VXVY: begin
                     p_in     = acc_step;
                     acc_in   = '0;
                     root_in  = '0;
                     cnt_in   = CNT_W'(ROOT_W - 1);
                     state_in = F_SQRT;
                  end
                  default: begin
                     acc_in = acc_step;
                  end
               endcase
            end
         end

         F_SQRT: begin
            // two bits of the radicand per step, acc holds the remainder
            alu_a   = rem_sh;
            alu_b   = {{(AW-ROOT_W-2){1'b0}}, root_ff, 2'b01};
            alu_sub = 1'b1;
            p_in    = p_ff << 2;
            cnt_in  = cnt_ff - CNT_W'(1);
            if (alu_carry) begin
               acc_in  = alu_res[AW-1:0];
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               acc_in  = rem_sh;
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            if (last_step) begin
               state_in = F_ABS;
            end
         end

         F_ABS: begin
            alu_a    = '0;
            alu_b    = AW'(num_ff);
            alu_sub  = num_ff[NUM_W-1];
            neg_in   = num_ff[NUM_W-1];
            acc_in   = alu_res[AW-1:0] << FRAC_W;
            mcand_in = AW'(root_ff) << FRAC_W;
            q_in     = '0;
            cnt_in   = CNT_W'(COEF_W - 1);
            if (root_ff == '0) begin
               res_in.coefficient    = '0;
               res_in.zero_spread    = 1'b1;
               res_in.count_overflow = 1'b0;
               state_in              = F_DONE;
            end else begin
               state_in = F_DIV;
            end
         end

         F_DIV: begin
            // restoring divide, one quotient bit per step
            alu_a    = acc_ff;
            alu_b    = mcand_ff;
            alu_sub  = 1'b1;
            mcand_in = mcand_ff >> 1;
            cnt_in   = cnt_ff - CNT_W'(1);
            q_in     = q_fin;
            if (alu_carry) begin
               acc_in = alu_res[AW-1:0];
            end
            if (last_step) begin
               res_in.zero_spread    = 1'b0;
               res_in.count_overflow = 1'b0;
               if (neg_ff) begin
                  res_in.coefficient = ~q_fin + COEF_W'(1);
               end else if (q_fin > COEF_MAX) begin
                  res_in.coefficient = COEF_MAX;
               end else begin
                  res_in.coefficient = q_fin;
               end
               state_in = F_DONE;
            end
         end

         F_DONE: begin
            if (ctl.ack) begin
               state_in = F_IDLE;
            end
         end

         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mop_ff    <= mop_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      cnt_ff    <= cnt_in;
      msub_ff   <= msub_in;
      msgn_ff   <= msgn_in;
      num_ff    <= num_in;
      vx_ff     <= vx_in;
      p_ff      <= p_in;
      root_ff   <= root_in;
      neg_ff    <= neg_in;
      q_ff      <= q_in;
      res_ff    <= res_in;
   end

   assign sts.done   = (state_ff == F_DONE);
   assign sts.result = res_ff;

endmodule
